// ===== hdl/hlr_pkg.sv =====
// ----------------------------------------------------------------------------
// Horizontal resize package
// Shared types and register indexes for the horizontal linear resizer.
// ----------------------------------------------------------------------------
package hlr_pkg;

    localparam logic CFG_SRC_WIDTH = 1'b0;
    localparam logic CFG_DST_WIDTH = 1'b1;

    // Controller states.
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECIDE,
        ST_DIVIDE,
        ST_EMIT,
        ST_FINISH
    } hlr_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_input;
        logic start_div;
        logic emit;
        logic finish;
    } hlr_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic need_div;
        logic has_result;
        logic more;
        logic div_done;
        logic out_free;
    } hlr_stat_t;

endpackage

// ===== hdl/horizontal_linear_resize.sv =====
// ----------------------------------------------------------------------------
// Horizontal linear resize
// Rescales each pixel row from src_width to dst_width by linear interpolation.
// ----------------------------------------------------------------------------
// One request at a time. Each request is captured and then, per result, decided and
// delivered; an interpolated result first goes through a shared bit-serial divider
// that reports completion. Flags run_last and frame_end ride on the last result of a
// request; the output register holds each result until taken and stalls the controller
// while it is full.
module horizontal_linear_resize
    import hlr_pkg::*;
#(
    parameter int MAX_WIDTH   = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_RATIO   = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [12:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [15:0] luma_in,
    input  logic [15:0] cb_in,
    input  logic [15:0] cr_in,
    input  logic        frame_last_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] luma_out,
    output logic [15:0] cb_out,
    output logic [15:0] cr_out,
    output logic        run_last,
    output logic        frame_end,
    output logic        ratio_error
);

    hlr_cmd_t  cmd;
    hlr_stat_t stat;

    assign cfg_ready = 1'b1;

    hlr_control u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .cmd       (cmd),
        .stat      (stat)
    );

    hlr_datapath #(
        .MAX_WIDTH   (MAX_WIDTH),
        .SAMPLE_BITS (SAMPLE_BITS),
        .MAX_RATIO   (MAX_RATIO)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .cfg_we        (cfg_valid),
        .cfg_sel       (cfg_index),
        .cfg_data      (cfg_data),
        .luma_in       (luma_in),
        .cb_in         (cb_in),
        .cr_in         (cr_in),
        .frame_last_in (frame_last_in),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .luma_out      (luma_out),
        .cb_out        (cb_out),
        .cr_out        (cr_out),
        .run_last      (run_last),
        .frame_end     (frame_end),
        .ratio_error   (ratio_error)
    );

endmodule

// ===== hdl/hlr_divider.sv =====
// ----------------------------------------------------------------------------
// Restoring divider
// Divides three sums by one divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module hlr_divider
    import hlr_pkg::*;
#(
    parameter int NUM_BITS = 32,
    parameter int DEN_BITS = 14
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [NUM_BITS-1:0] num0,
    input  logic [NUM_BITS-1:0] num1,
    input  logic [NUM_BITS-1:0] num2,
    input  logic [DEN_BITS-1:0] den,
    output logic                done,
    output logic [NUM_BITS-1:0] quo0,
    output logic [NUM_BITS-1:0] quo1,
    output logic [NUM_BITS-1:0] quo2
);

    localparam int CNT_BITS = $clog2(NUM_BITS + 1);

    logic [CNT_BITS-1:0] count_reg;
    logic                busy_reg;
    logic [NUM_BITS-1:0] q_reg [3];
    logic [DEN_BITS:0]   r_reg [3];
    logic [DEN_BITS-1:0] den_reg;

    // Iterate one bit per cycle over all three components.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            count_reg <= '0;
            done      <= 1'b0;
        end
        else
        begin
            done <= 1'b0;
            if (start)
            begin
                busy_reg  <= 1'b1;
                count_reg <= CNT_BITS'(NUM_BITS);
            end
            else if (busy_reg)
            begin
                count_reg <= count_reg - 1'b1;
                if (count_reg == CNT_BITS'(1))
                begin
                    busy_reg <= 1'b0;
                    done     <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        logic [DEN_BITS+1:0] trial;
        if (start)
        begin
            q_reg[0] <= num0;
            q_reg[1] <= num1;
            q_reg[2] <= num2;
            r_reg[0] <= '0;
            r_reg[1] <= '0;
            r_reg[2] <= '0;
            den_reg  <= den;
        end
        else if (busy_reg)
        begin
            for (int k = 0; k < 3; k++)
            begin
                trial = {r_reg[k], q_reg[k][NUM_BITS-1]};
                if (trial >= {2'b00, den_reg})
                begin
                    r_reg[k] <= (DEN_BITS+1)'(trial - {2'b00, den_reg});
                    q_reg[k] <= {q_reg[k][NUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    r_reg[k] <= trial[DEN_BITS:0];
                    q_reg[k] <= {q_reg[k][NUM_BITS-2:0], 1'b0};
                end
            end
        end
    end

    assign quo0 = q_reg[0];
    assign quo1 = q_reg[1];
    assign quo2 = q_reg[2];

endmodule

// ===== hdl/hlr_datapath.sv =====
// ----------------------------------------------------------------------------
// Resize datapath
// Row state, weight calculation, division and the output register.
// ----------------------------------------------------------------------------
module hlr_datapath
    import hlr_pkg::*;
#(
    parameter int MAX_WIDTH   = 4096,
    parameter int SAMPLE_BITS = 16,
    parameter int MAX_RATIO   = 32
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  hlr_cmd_t    cmd,
    output hlr_stat_t   stat,
    input  logic        cfg_we,
    input  logic        cfg_sel,
    input  logic [12:0] cfg_data,
    input  logic [15:0] luma_in,
    input  logic [15:0] cb_in,
    input  logic [15:0] cr_in,
    input  logic        frame_last_in,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [15:0] luma_out,
    output logic [15:0] cb_out,
    output logic [15:0] cr_out,
    output logic        run_last,
    output logic        frame_end,
    output logic        ratio_error
);

    localparam int WB = $clog2(MAX_WIDTH + 1);
    localparam int NB = SAMPLE_BITS + WB + 1;
    localparam int RB = $clog2(MAX_RATIO + 2);

    logic [12:0] src_reg, dst_reg;
    logic [WB-1:0] phase_reg, col_reg, off_reg, rowcnt_reg;
    logic [SAMPLE_BITS-1:0] prev_reg [3];
    logic [SAMPLE_BITS-1:0] cur_reg [3];
    logic flast_reg;
    logic [RB-1:0] n_reg;
    logic lerp_reg, err_reg, first_reg;

    // Effective widths, clamped to the supported range.
    logic [WB-1:0] sw, dw, s, d;
    always_comb
    begin
        sw = (src_reg == 13'd0) ? WB'(1) :
             (32'(src_reg) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(src_reg);
        dw = (dst_reg == 13'd0) ? WB'(1) :
             (32'(dst_reg) > MAX_WIDTH) ? WB'(MAX_WIDTH) : WB'(dst_reg);
        s = sw - 1'b1;
        d = dw - 1'b1;
    end

    logic mode_copy, mode_err, mode_shrink;
    always_comb
    begin
        mode_copy   = (sw == dw);
        mode_err    = !mode_copy && (dw > sw) &&
                      (32'(d) > MAX_RATIO * ((s != '0) ? 32'(s) : 32'd1));
        mode_shrink = !mode_copy && !mode_err && (dw < sw);
    end

    // Enlarge loop conditions for the current state.
    logic [WB-1:0] cm1;
    logic lerp_cond, copy_cond, cap_ok;
    always_comb
    begin
        cm1       = col_reg - 1'b1;
        cap_ok    = 32'(n_reg) < MAX_RATIO + 1;
        lerp_cond = (col_reg != '0) && (rowcnt_reg < dw) && (off_reg == cm1) &&
                    (phase_reg != '0) && cap_ok && first_reg;
        copy_cond = (rowcnt_reg < dw) && (off_reg == col_reg) &&
                    (phase_reg == '0) && cap_ok;
    end

    // Shrink phase for this input.
    logic [WB:0] sp_sum;
    logic [WB-1:0] sp;
    logic s_hit;
    always_comb
    begin
        sp_sum = {1'b0, phase_reg} + {1'b0, d};
        s_hit  = sp_sum >= {1'b0, s};
        sp     = s_hit ? WB'(sp_sum - {1'b0, s}) : WB'(sp_sum);
    end

    // Weights for the result about to be divided.
    logic [WB-1:0] wprev, wcur;
    always_comb
    begin
        if (mode_shrink)
        begin
            wprev = sp;
            wcur  = d - sp;
        end
        else
        begin
            wprev = d - phase_reg;
            wcur  = phase_reg;
        end
    end

    // Phase step for one enlarge result.
    logic [WB:0] ep_sum;
    always_comb
    begin
        ep_sum = {1'b0, phase_reg} + {1'b0, s};
    end

    // State after the result being delivered, to tell whether it is the last one.
    logic ep_wrap, next_cap, next_lerp, next_copy, last_result;
    logic [WB-1:0] ep_phase, ep_off, ep_rows;
    always_comb
    begin
        ep_wrap     = ep_sum >= {1'b0, d};
        ep_phase    = ep_wrap ? WB'(ep_sum - {1'b0, d}) : WB'(ep_sum);
        ep_off      = ep_wrap ? off_reg + 1'b1 : off_reg;
        ep_rows     = rowcnt_reg + 1'b1;
        next_cap    = 32'(n_reg) + 1 < MAX_RATIO + 1;
        next_lerp   = (col_reg != '0) && (ep_rows < dw) && (ep_off == cm1) &&
                      (ep_phase != '0) && next_cap && first_reg && lerp_cond;
        next_copy   = (ep_rows < dw) && (ep_off == col_reg) &&
                      (ep_phase == '0) && next_cap;
        last_result = mode_copy || mode_err || mode_shrink ||
                      !(next_lerp || next_copy);
    end

    // Divider fed by the current weights; numerators are latched at start.
    logic [NB-1:0] num [3];
    logic [NB-1:0] quo [3];
    logic div_done;
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            num[k] = NB'(prev_reg[k] * wprev) + NB'(cur_reg[k] * wcur);
        end
    end

    hlr_divider #(.NUM_BITS(NB), .DEN_BITS(WB)) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.start_div),
        .num0  (num[0]),
        .num1  (num[1]),
        .num2  (num[2]),
        .den   (d),
        .done  (div_done),
        .quo0  (quo[0]),
        .quo1  (quo[1]),
        .quo2  (quo[2])
    );

    // Decision for the next result of the current input.
    always_comb
    begin
        stat.out_free = !out_valid || out_ready;
        stat.div_done = div_done;
        stat.need_div = 1'b0;
        stat.has_result = 1'b0;
        if (mode_copy || mode_err)
        begin
            stat.has_result = (n_reg == '0);
        end
        else if (mode_shrink)
        begin
            if (n_reg == '0)
            begin
                if (col_reg == '0)
                    stat.has_result = first_reg;
                else if (s_hit && first_reg)
                begin
                    stat.has_result = 1'b1;
                    stat.need_div   = (sp != '0);
                end
            end
        end
        else
        begin
            stat.has_result = lerp_cond || copy_cond;
            stat.need_div   = lerp_cond;
        end
        stat.more = stat.has_result;
    end

    // Configuration and row state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            src_reg    <= 13'd640;
            dst_reg    <= 13'd640;
            phase_reg  <= '0;
            col_reg    <= '0;
            off_reg    <= '0;
            rowcnt_reg <= '0;
            n_reg      <= '0;
            first_reg  <= 1'b0;
            out_valid  <= 1'b0;
            for (int k = 0; k < 3; k++)
                prev_reg[k] <= '0;
        end
        else
        begin
            if (out_valid && out_ready)
                out_valid <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_sel == CFG_SRC_WIDTH)
                    src_reg <= cfg_data;
                else
                    dst_reg <= cfg_data;
                phase_reg  <= '0;
                col_reg    <= '0;
                off_reg    <= '0;
                rowcnt_reg <= '0;
            end
            if (cmd.load_input)
            begin
                n_reg     <= '0;
                first_reg <= 1'b1;
            end
            if (cmd.start_div)
            begin
                // Weights are taken on this cycle; nothing else changes.
            end
            if (cmd.emit)
            begin
                out_valid <= 1'b1;
                n_reg     <= n_reg + 1'b1;
                if (!mode_copy && !mode_err)
                begin
                    if (mode_shrink)
                    begin
                        phase_reg <= (col_reg == '0) ? '0 : sp;
                        first_reg <= 1'b0;
                    end
                    else
                    begin
                        if (!lerp_cond)
                            first_reg <= 1'b0;
                        rowcnt_reg <= rowcnt_reg + 1'b1;
                        if (ep_sum >= {1'b0, d})
                        begin
                            phase_reg <= WB'(ep_sum - {1'b0, d});
                            off_reg   <= off_reg + 1'b1;
                        end
                        else
                            phase_reg <= WB'(ep_sum);
                    end
                end
            end
            if (cmd.finish)
            begin
                if (mode_shrink && first_reg)
                    phase_reg <= (col_reg == '0) ? '0 : sp;
                for (int k = 0; k < 3; k++)
                    prev_reg[k] <= cur_reg[k];
                if (flast_reg || (32'(col_reg) + 1 >= 32'(sw)))
                begin
                    phase_reg  <= '0;
                    col_reg    <= '0;
                    off_reg    <= '0;
                    rowcnt_reg <= '0;
                end
                else
                    col_reg <= col_reg + 1'b1;
            end
        end
    end

    // Input capture, result kind and output payload.
    always_ff @(posedge clk)
    begin
        if (cmd.load_input)
        begin
            cur_reg[0] <= luma_in[SAMPLE_BITS-1:0];
            cur_reg[1] <= cb_in[SAMPLE_BITS-1:0];
            cur_reg[2] <= cr_in[SAMPLE_BITS-1:0];
            flast_reg  <= frame_last_in;
        end
        if (!cmd.start_div && !cmd.emit)
        begin
            lerp_reg <= stat.need_div;
            err_reg  <= mode_err;
        end
        if (cmd.emit)
        begin
            // The last result of a request carries the end flags.
            run_last    <= last_result;
            frame_end   <= last_result && flast_reg;
            ratio_error <= err_reg;
            if (err_reg)
            begin
                luma_out <= '0;
                cb_out   <= '0;
                cr_out   <= '0;
            end
            else if (lerp_reg)
            begin
                luma_out <= 16'(quo[0][SAMPLE_BITS-1:0]);
                cb_out   <= 16'(quo[1][SAMPLE_BITS-1:0]);
                cr_out   <= 16'(quo[2][SAMPLE_BITS-1:0]);
            end
            else
            begin
                luma_out <= 16'(cur_reg[0]);
                cb_out   <= 16'(cur_reg[1]);
                cr_out   <= 16'(cur_reg[2]);
            end
        end
    end

endmodule

// ===== hdl/hlr_control.sv =====
// ----------------------------------------------------------------------------
// Resize controller
// Sequences input capture, division and result delivery for one request.
// ----------------------------------------------------------------------------
module hlr_control
    import hlr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    output hlr_cmd_t  cmd,
    input  hlr_stat_t stat
);

    hlr_state_t state_reg, state_next;

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_input = 1'b1;
                    state_next     = ST_DECIDE;
                end
            end
            ST_DECIDE:
            begin
                if (!stat.has_result)
                    state_next = ST_FINISH;
                else if (stat.need_div)
                begin
                    cmd.start_div = 1'b1;
                    state_next    = ST_DIVIDE;
                end
                else
                    state_next = ST_EMIT;
            end
            ST_DIVIDE:
            begin
                if (stat.div_done)
                    state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_DECIDE;
                end
            end
            ST_FINISH:
            begin
                // Update the row state and return for the next request.
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ===== tb/hlr_scoreboard.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Resize result scoreboard
// Predicts the rows that the horizontal resizer produces for each accepted
// request and compares the delivered results with them in order.
// ----------------------------------------------------------------------------
typedef struct packed {
    logic [15:0] luma;
    logic [15:0] cb;
    logic [15:0] cr;
    logic        run_last;
    logic        frame_end;
    logic        ratio_error;
} resize_px_t;

class hlr_scoreboard;
    localparam int MAX_WIDTH = 4096;
    localparam int MAX_RATIO = 32;

    int unsigned src_width;
    int unsigned dst_width;
    int unsigned phase;
    int unsigned column;
    int unsigned offset;
    int unsigned row_done;
    int unsigned prev_px [3];
    resize_px_t  pending_px [$];
    int          mismatches;

    function new();
        src_width = 640;
        dst_width = 640;
        prev_px   = '{0, 0, 0};
        mismatches = 0;
        restart_row();
    endfunction

    function void restart_row();
        phase    = 0;
        column   = 0;
        offset   = 0;
        row_done = 0;
    endfunction

    function int unsigned clamp_width(int unsigned w);
        if (w < 1)
            return 1;
        if (w > MAX_WIDTH)
            return MAX_WIDTH;
        return w;
    endfunction

    // A register write also restarts the current row.
    function void set_width(logic idx, logic [12:0] value);
        if (idx == hlr_pkg::CFG_SRC_WIDTH)
            src_width = 32'(value);
        else
            dst_width = 32'(value);
        restart_row();
    endfunction

    function void push_px(int unsigned y, int unsigned u, int unsigned v, logic err);
        resize_px_t r;
        r.luma = y[15:0];
        r.cb = u[15:0];
        r.cr = v[15:0];
        r.run_last = 1'b0;
        r.frame_end = 1'b0;
        r.ratio_error = err;
        pending_px.push_back(r);
    endfunction

    // Works out the results that one accepted source pixel causes.
    function void note_pixel(logic [15:0] y, logic [15:0] u, logic [15:0] v, logic flast);
        int unsigned sw, dw, s, d, p, c, n, k, base;
        int unsigned cur [3];
        sw = clamp_width(src_width);
        dw = clamp_width(dst_width);
        s = sw - 1;
        d = dw - 1;
        c = column;
        n = 0;
        base = pending_px.size();
        cur = '{32'(y), 32'(u), 32'(v)};
        if (sw == dw) begin
            push_px(cur[0], cur[1], cur[2], 1'b0);
            n++;
        end
        else if (dw > sw && d > MAX_RATIO * (s > 0 ? s : 1)) begin
            push_px(0, 0, 0, 1'b1);
            n++;
        end
        else if (dw < sw) begin
            if (c == 0) begin
                push_px(cur[0], cur[1], cur[2], 1'b0);
                n++;
                phase = 0;
            end
            else begin
                p = phase + d;
                if (p >= s) begin
                    p -= s;
                    if (p == 0)
                        push_px(cur[0], cur[1], cur[2], 1'b0);
                    else
                        push_px((prev_px[0] * p + cur[0] * (d - p)) / d,
                                (prev_px[1] * p + cur[1] * (d - p)) / d,
                                (prev_px[2] * p + cur[2] * (d - p)) / d, 1'b0);
                    n++;
                end
                phase = p;
            end
        end
        else begin
            // Enlarging: finish the interval that ends at this pixel first.
            if (c > 0) begin
                while (row_done < dw && offset == c - 1 && phase != 0
                       && n < MAX_RATIO + 1) begin
                    p = phase;
                    push_px((prev_px[0] * (d - p) + cur[0] * p) / d,
                            (prev_px[1] * (d - p) + cur[1] * p) / d,
                            (prev_px[2] * (d - p) + cur[2] * p) / d, 1'b0);
                    n++;
                    row_done++;
                    phase += s;
                    if (phase >= d) begin
                        phase -= d;
                        offset++;
                    end
                end
            end
            while (row_done < dw && offset == c && phase == 0 && n < MAX_RATIO + 1) begin
                push_px(cur[0], cur[1], cur[2], 1'b0);
                n++;
                row_done++;
                phase += s;
                if (phase >= d) begin
                    phase -= d;
                    offset++;
                end
            end
        end
        for (k = 0; k < 3; k++)
            prev_px[k] = cur[k];
        if (n > 0) begin
            pending_px[base + n - 1].run_last = 1'b1;
            pending_px[base + n - 1].frame_end = flast;
        end
        if (flast || c + 1 >= sw)
            restart_row();
        else
            column = c + 1;
    endfunction

    // Compares one delivered result with the oldest prediction.
    function void check_px(resize_px_t got);
        resize_px_t want;
        if (pending_px.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: unexpected result %h", got);
            return;
        end
        want = pending_px.pop_front();
        if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
                $display("ERROR: result mismatch expected y=%h u=%h v=%h rl=%b fe=%b re=%b, got y=%h u=%h v=%h rl=%b fe=%b re=%b",
                         want.luma, want.cb, want.cr, want.run_last, want.frame_end,
                         want.ratio_error, got.luma, got.cb, got.cr, got.run_last,
                         got.frame_end, got.ratio_error);
        end
    endfunction
endclass

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Horizontal resize testbench
// Drives pixel rows through the resizer under several width settings with
// random gaps and stalls and checks every result against a prediction.
// ----------------------------------------------------------------------------
module tb_top;
    import hlr_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [12:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] luma_in;
    logic [15:0] cb_in;
    logic [15:0] cr_in;
    logic        frame_last_in;
    logic        out_valid;
    logic        out_ready;
    logic [15:0] luma_out;
    logic [15:0] cb_out;
    logic [15:0] cr_out;
    logic        run_last;
    logic        frame_end;
    logic        ratio_error;

    hlr_scoreboard resize_board;
    int            idle_cycles;
    bit            sink_hold;
    bit            timed_out;

    horizontal_linear_resize DUT (.*);

    // Clock with a 12 ns period.
    initial clk = 1'b0;
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Receiver: random stalls, with a long hold-off when requested.
    initial
    begin
        int gap;
        out_ready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (sink_hold)
            begin
                out_ready <= 1'b0;
                repeat (400) @(negedge clk);
                sink_hold = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15);
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    // Check each result that is taken.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
            resize_board.check_px({luma_out, cb_out, cr_out, run_last,
                                   frame_end, ratio_error});
    end

    // Watchdog on cycles without any handshake on input, output or configuration.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic write_width(logic idx, logic [12:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        resize_board.set_width(idx, value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_pixel(logic [15:0] y, logic [15:0] u, logic [15:0] v,
                              logic flast, bit no_gap);
        int gap;
        gap = no_gap ? 0 : (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 15));
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        in_valid <= 1'b1;
        luma_in <= y;
        cb_in <= u;
        cr_in <= v;
        frame_last_in <= flast;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        resize_board.note_pixel(y, u, v, flast);
    endtask

    task automatic end_burst();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Wait until every predicted result has arrived, then let the block settle.
    task automatic drain_results();
        while (resize_board.pending_px.size() != 0)
            @(posedge clk);
        repeat (100) @(posedge clk);
    endtask

    task automatic send_random_pixel(int frame_odds);
        send_pixel(16'($urandom), 16'($urandom), 16'($urandom),
                   ($urandom_range(0, frame_odds) == 0), 1'b0);
    endtask

    // One width setting followed by random rows.
    task automatic run_phase(int unsigned sw, int unsigned dw, int count);
        write_width(CFG_SRC_WIDTH, sw[12:0]);
        write_width(CFG_DST_WIDTH, dw[12:0]);
        for (int i = 0; i < count; i++)
            send_random_pixel(40);
        end_burst();
        drain_results();
    endtask

    initial
    begin
        resize_board = new();
        idle_cycles = 0;
        sink_hold = 1'b0;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_SRC_WIDTH;
        cfg_data = '0;
        in_valid = 1'b0;
        luma_in = '0;
        cb_in = '0;
        cr_in = '0;
        frame_last_in = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: pass-through at reset widths with sample extremes.
        send_pixel(16'h0000, 16'hFFFF, 16'h0000, 1'b0, 1'b1);
        send_pixel(16'hFFFF, 16'h0000, 16'hFFFF, 1'b0, 1'b1);
        send_pixel(16'hAAAA, 16'h5555, 16'hFFFF, 1'b1, 1'b0);
        end_burst();
        drain_results();

        // Directed: shrink 5 -> 3, with an early frame end.
        write_width(CFG_SRC_WIDTH, 13'd5);
        write_width(CFG_DST_WIDTH, 13'd3);
        for (int i = 0; i < 7; i++)
            send_pixel(16'(16'hFFFF - i), 16'(16'h1000 * i), 16'hFFFF, (i == 6), 1'b0);
        end_burst();
        drain_results();

        // Directed: enlarge 2 -> 33, the largest allowed ratio, and 2 -> 34, an error.
        write_width(CFG_SRC_WIDTH, 13'd2);
        write_width(CFG_DST_WIDTH, 13'd33);
        send_pixel(16'h0000, 16'hFFFF, 16'h8000, 1'b0, 1'b0);
        send_pixel(16'hFFFF, 16'h0000, 16'h0001, 1'b0, 1'b0);
        end_burst();
        drain_results();
        write_width(CFG_DST_WIDTH, 13'd34);
        send_pixel(16'h1234, 16'h5678, 16'h9ABC, 1'b0, 1'b0);
        send_pixel(16'h1234, 16'h5678, 16'h9ABC, 1'b1, 1'b0);
        end_burst();
        drain_results();

        // Directed: widths of 0 and above the maximum, and a one-pixel row.
        write_width(CFG_SRC_WIDTH, 13'd0);
        write_width(CFG_DST_WIDTH, 13'd8191);
        send_pixel(16'hFFFF, 16'hFFFF, 16'hFFFF, 1'b1, 1'b0);
        end_burst();
        drain_results();
        write_width(CFG_SRC_WIDTH, 13'd4096);
        write_width(CFG_DST_WIDTH, 13'd1);
        send_pixel(16'h0F0F, 16'hF0F0, 16'h00FF, 1'b0, 1'b0);
        send_pixel(16'h0F0F, 16'hF0F0, 16'h00FF, 1'b1, 1'b0);
        end_burst();
        drain_results();

        // Back-pressure: hold the receiver off while pixels keep coming.
        write_width(CFG_SRC_WIDTH, 13'd3);
        write_width(CFG_DST_WIDTH, 13'd20);
        sink_hold = 1'b1;
        for (int i = 0; i < 6; i++)
            send_pixel(16'($urandom), 16'($urandom), 16'($urandom), 1'b0, 1'b1);
        end_burst();
        drain_results();

        // Random phases over shrink, copy and enlarge.
        run_phase(7, 7, 40);
        run_phase(9, 4, 60);
        run_phase(4, 11, 50);
        run_phase(4096, 4095, 30);
        run_phase(12, 1, 30);
        run_phase(1, 33, 15);
        run_phase(3, 70, 15);
        run_phase(6, 17, 40);
        for (int j = 0; j < 3; j++)
            run_phase($urandom_range(1, 24), $urandom_range(1, 48), 25);

        if (resize_board.mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end
endmodule
